[src/mtpc_pkg.sv]
// Package for the memory test pattern checker.
// Holds widths, pattern constants, mode and register codes, controller state and control structs.
// No dependencies.
package mtpc_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [WORD_W-1:0] HASH_MUL_A  = 32'h7feb352d;
	localparam logic [WORD_W-1:0] HASH_MUL_B  = 32'h846ca68b;
	localparam logic [WORD_W-1:0] CHECK_EVEN  = 32'hAAAAAAAA;
	localparam logic [WORD_W-1:0] CHECK_ODD   = 32'h55555555;
	localparam logic [WORD_W-1:0] ALL_ONES    = 32'hFFFFFFFF;
	localparam logic [WORD_W-1:0] INJECT_MASK = 32'h0BADBEEF;

	localparam logic [MODE_W-1:0] MODE_ZEROS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ONES  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HASH  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INJECT_ENABLE = 2'd1;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_VERIFY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL_A = 4'b0010,
		ST_MUL_B = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic step_a;
		logic step_b;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage

[src/memory_test_pattern_checker_core.sv]
// Top level of the memory test pattern checker.
// Holds the configuration registers and joins mtpc_ctrl and mtpc_dp. Depends on mtpc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat per memory word, carrying command,
//   word_index and four read-back lanes. A beat is taken when in_valid is high and
//   in_stall is low.
//   Output channel (out_valid / out_stall): one result beat per input beat, in order:
//   fault_index, expected_word, actual_word, mismatch and the running error_total.
//   Config channel (cfg_valid / cfg_ready): index 0 pattern_mode, index 1 inject_enable;
//   other indexes are ignored. cfg_ready is always high. Write only while idle.
// Timing:
//   An item passes through the states ST_IDLE (accept), ST_MUL_A, ST_MUL_B and ST_FIN
//   (result load). The integer hash does two 32x32 multiplies, each in a state of its own, on one datapath.
//   The input is stalled while an item is in flight.
// Reset:
//   arst_n clears the controller, the output valid and the error count; pattern_mode
//   returns to hashed checkerboard and injection is off.
// Back-pressure:
//   A result waits in the output register while out_stall is high. The next item is
//   still taken and hashed, and holds in its final step until the output frees up.
module memory_test_pattern_checker_core import mtpc_pkg::*; #(
	parameter logic [31:0] INJECT_INDEX = 32'd1337
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [WORD_W-1:0]     word_index,
	input  logic [WORD_W-1:0]     read_lane0,
	input  logic [WORD_W-1:0]     read_lane1,
	input  logic [WORD_W-1:0]     read_lane2,
	input  logic [WORD_W-1:0]     read_lane3,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [WORD_W-1:0]     fault_index,
	output logic [WORD_W-1:0]     expected_word,
	output logic [WORD_W-1:0]     actual_word,
	output logic                  mismatch,
	output logic [WORD_W-1:0]     error_total,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [MODE_W-1:0] pattern_mode_q;
	logic              inject_enable_q;
	dp_cmd_t           dp_cmd;
	dp_sts_t           dp_sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q  <= MODE_HASH;
			inject_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PATTERN_MODE:  pattern_mode_q  <= cfg_data[MODE_W-1:0];
				REG_INJECT_ENABLE: inject_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	mtpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	mtpc_dp #(
		.INJECT_INDEX (INJECT_INDEX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.sts           (dp_sts),
		.pattern_mode  (pattern_mode_q),
		.inject_enable (inject_enable_q),
		.command       (command),
		.word_index    (word_index),
		.read_lane0    (read_lane0),
		.read_lane1    (read_lane1),
		.read_lane2    (read_lane2),
		.read_lane3    (read_lane3),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fault_index   (fault_index),
		.expected_word (expected_word),
		.actual_word   (actual_word),
		.mismatch      (mismatch),
		.error_total   (error_total)
	);

endmodule

[src/mtpc_ctrl.sv]
// Controller for the memory test pattern checker.
// Sequences accept, two hash multiply steps and the result load. Depends on mtpc_pkg.
module mtpc_ctrl import mtpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.step_a = 1'b1;
				state_d    = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.step_b = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/mtpc_dp.sv]
// Datapath for the memory test pattern checker.
// Item registers, staged integer hash, pattern select, lane compare, error counter, result beat.
// Depends on mtpc_pkg.
module mtpc_dp import mtpc_pkg::*; #(
	parameter logic [31:0] INJECT_INDEX = 32'd1337
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic [MODE_W-1:0] pattern_mode,
	input  logic              inject_enable,
	input  logic              command,
	input  logic [WORD_W-1:0] word_index,
	input  logic [WORD_W-1:0] read_lane0,
	input  logic [WORD_W-1:0] read_lane1,
	input  logic [WORD_W-1:0] read_lane2,
	input  logic [WORD_W-1:0] read_lane3,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] fault_index,
	output logic [WORD_W-1:0] expected_word,
	output logic [WORD_W-1:0] actual_word,
	output logic              mismatch,
	output logic [WORD_W-1:0] error_total
);

	logic              cmd_q;
	logic [WORD_W-1:0] idx_q;
	logic [WORD_W-1:0] lane0_q;
	logic [WORD_W-1:0] lane1_q;
	logic [WORD_W-1:0] lane2_q;
	logic [WORD_W-1:0] lane3_q;
	logic [WORD_W-1:0] mix_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] err_cnt_q;
	logic [WORD_W-1:0] fault_index_q;
	logic [WORD_W-1:0] expected_q;
	logic [WORD_W-1:0] actual_q;
	logic              mismatch_q;

	logic [WORD_W-1:0] mix_b_in;
	logic [WORD_W-1:0] hash;
	logic [WORD_W-1:0] pattern;
	logic [WORD_W-1:0] exp_word;
	logic              miss;
	logic [WORD_W-1:0] err_cnt_d;

	assign mix_b_in = mix_q ^ (mix_q >> 15);
	assign hash     = mix_q ^ (mix_q >> 16);

	always_comb begin
		case (pattern_mode)
			MODE_ZEROS: pattern = '0;
			MODE_ONES:  pattern = ALL_ONES;
			default:    pattern = (idx_q[0] ? CHECK_ODD : CHECK_EVEN) ^ hash;
		endcase
	end

	always_comb begin
		exp_word  = pattern;
		miss      = 1'b0;
		err_cnt_d = err_cnt_q;
		if (cmd_q == CMD_WRITE) begin
			if (inject_enable && (idx_q == INJECT_INDEX)) begin
				exp_word = pattern ^ INJECT_MASK;
			end
		end else begin
			miss = (lane0_q != pattern) || (lane1_q != pattern) ||
			       (lane2_q != pattern) || (lane3_q != pattern);
			if (miss && (err_cnt_q != ALL_ONES)) begin
				err_cnt_d = err_cnt_q + WORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q   <= command;
			idx_q   <= word_index;
			lane0_q <= read_lane0;
			lane1_q <= read_lane1;
			lane2_q <= read_lane2;
			lane3_q <= read_lane3;
			mix_q   <= word_index ^ (word_index >> 16);
		end else if (cmd.step_a) begin
			mix_q <= mix_q * HASH_MUL_A;
		end else if (cmd.step_b) begin
			mix_q <= mix_b_in * HASH_MUL_B;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			fault_index_q <= idx_q;
			expected_q    <= exp_word;
			actual_q      <= (cmd_q == CMD_VERIFY) ? lane0_q : '0;
			mismatch_q    <= miss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			err_cnt_q   <= '0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				err_cnt_q   <= err_cnt_d;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_busy  = out_valid_q && out_stall;
	assign out_valid     = out_valid_q;
	assign fault_index   = fault_index_q;
	assign expected_word = expected_q;
	assign actual_word   = actual_q;
	assign mismatch      = mismatch_q;
	assign error_total   = err_cnt_q;

endmodule

[src/mtpc_checker.sv]
// Port-level checks for the memory test pattern checker, bound to the top level.
// Depends on mtpc_pkg and memory_test_pattern_checker_core.
module mtpc_checker import mtpc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              mismatch,
	input logic [WORD_W-1:0] error_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mismatch |-> error_total != '0)
		else $error("mismatch reported with zero error total");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid ##1 out_valid |-> error_total >= $past(error_total))
		else $error("error total went down");

endmodule

bind memory_test_pattern_checker_core mtpc_checker u_mtpc_checker (.*);
